FILE: rtl/core/gregorian_date_add_days_assert.svh
// Assertion macros shared by the date adder modules.
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define GDAD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define GDAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gdad_pkg.sv
`timescale 1ns / 1ps

package gdad_pkg;

  // Gregorian cycle lengths
  localparam int unsigned LEAP_CYCLE = 400;
  localparam int unsigned CENTURY    = 100;

  // Year residue modulo the 400-year cycle
  localparam int unsigned R400_W = 9;
  typedef logic [R400_W-1:0] r400_t;

  // Reciprocal of 400 for years below 2^20:
  // floor(y / 400) = (y * R400_RECIP) >> R400_SHIFT
  localparam int unsigned R400_RECIP   = 1342178;
  localparam int unsigned R400_RECIP_W = 21;
  localparam int unsigned R400_SHIFT   = 29;

  typedef logic [3:0] month_t;
  typedef logic [4:0] mday_t;

  localparam month_t MON_JAN = 4'd1;
  localparam month_t MON_FEB = 4'd2;
  localparam month_t MON_APR = 4'd4;
  localparam month_t MON_JUN = 4'd6;
  localparam month_t MON_SEP = 4'd9;
  localparam month_t MON_NOV = 4'd11;
  localparam month_t MON_DEC = 4'd12;

  localparam mday_t LEN_LONG     = 5'd31;
  localparam mday_t LEN_SHORT    = 5'd30;
  localparam mday_t LEN_FEB_LEAP = 5'd29;
  localparam mday_t LEN_FEB      = 5'd28;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Leap year from the residue modulo 400
  function automatic logic is_leap(r400_t r);
    return (r[1:0] == 2'b00) && (r != r400_t'(CENTURY)) &&
           (r != r400_t'(2 * CENTURY)) && (r != r400_t'(3 * CENTURY));
  endfunction

  // Month length; codes outside 1..12 read as 31 and are screened elsewhere
  function automatic mday_t month_len(month_t m, logic leap);
    mday_t len;
    unique case (m) inside
      MON_FEB:                            len = leap ? LEN_FEB_LEAP : LEN_FEB;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_SHORT;
      default:                            len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/gdad_front.sv
`timescale 1ns / 1ps

module gdad_front import gdad_pkg::*; #(
  parameter int DAY_COUNT_WIDTH = 16,
  parameter int YEAR_WIDTH      = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [4:0]                             start_day,
  input  logic [3:0]                             start_month,
  input  logic [YEAR_WIDTH-1:0]                  start_year,
  input  logic [DAY_COUNT_WIDTH-1:0]             add_days,
  input  q_status_t                              q_stat,
  output logic                                   push,
  output logic [DAY_COUNT_WIDTH+YEAR_WIDTH+14:0] push_data
);

  localparam int SUM_W  = DAY_COUNT_WIDTH + 1;
  localparam int PROD_W = YEAR_WIDTH + R400_RECIP_W;

  typedef enum logic [1:0] {S_IDLE, S_QUOT, S_REM, S_PUSH} state_t;

  state_t                     state;
  logic [4:0]                 day;
  month_t                     month;
  logic [YEAR_WIDTH-1:0]      year;
  logic [DAY_COUNT_WIDTH-1:0] count;
  logic [YEAR_WIDTH-1:0]      quot;
  r400_t                      rem;

  logic                  leap;
  mday_t                 mlen;
  logic                  date_ok;
  logic [SUM_W-1:0]      day_sum;
  logic [PROD_W-1:0]     prod;
  logic [YEAR_WIDTH-1:0] quot_x400;

  // Year modulo 400: reciprocal multiply for the quotient, then subtract
  always_comb begin
    prod      = PROD_W'(year) * PROD_W'(R400_RECIP);
    quot_x400 = quot * YEAR_WIDTH'(LEAP_CYCLE);
  end

  // Date check on the reduced year
  always_comb begin
    leap    = is_leap(rem);
    mlen    = month_len(month, leap);
    date_ok = (year != '0) && (month >= MON_JAN) && (month <= MON_DEC) &&
              (day != 5'd0) && (day <= mlen);
    day_sum = SUM_W'(day) + SUM_W'(count);
  end

  assign busy      = (state != S_IDLE);
  assign push      = (state == S_PUSH) && !q_stat.full;
  assign push_data = {date_ok, day_sum, month, year, rem};

  // Accept, reduce year modulo 400, hand word to the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            day   <= start_day;
            month <= start_month;
            year  <= start_year;
            count <= add_days;
            state <= S_QUOT;
          end
        end
        S_QUOT: begin
          quot  <= YEAR_WIDTH'(prod >> R400_SHIFT);
          state <= S_REM;
        end
        S_REM: begin
          rem   <= r400_t'(year - quot_x400);
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!q_stat.full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/gdad_queue.sv
`timescale 1ns / 1ps
`include "gregorian_date_add_days_assert.svh"

module gdad_queue import gdad_pkg::*; #(
  parameter int WIDTH = 45
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_status_t        q_stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign pop_data     = mem[rd_ptr];
  assign q_stat.full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (fill == '0);

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `GDAD_ASSERT_IMP(a_no_overflow, clk, rst, push, !q_stat.full, "push into full queue")
  `GDAD_ASSERT_IMP(a_no_underflow, clk, rst, pop, !q_stat.empty, "pop from empty queue")
  `GDAD_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= CNT_W'(QUEUE_DEPTH), "fill too high")

endmodule

FILE: rtl/core/gdad_back.sv
`timescale 1ns / 1ps
`include "gregorian_date_add_days_assert.svh"

module gdad_back import gdad_pkg::*; #(
  parameter int DAY_COUNT_WIDTH = 16,
  parameter int YEAR_WIDTH      = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  q_status_t                              q_stat,
  output logic                                   pop,
  input  logic [DAY_COUNT_WIDTH+YEAR_WIDTH+14:0] pop_data,
  output logic                                   done,
  output logic                                   date_valid,
  output logic [4:0]                             new_day,
  output logic [3:0]                             new_month,
  output logic [YEAR_WIDTH-1:0]                  new_year,
  output logic                                   year_overflow
);

  localparam int SUM_W = DAY_COUNT_WIDTH + 1;
  localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = {YEAR_WIDTH{1'b1}};

  typedef enum logic {B_IDLE, B_RUN} state_t;

  state_t                state;
  logic                  vld;
  logic [SUM_W-1:0]      d;
  month_t                m;
  logic [YEAR_WIDTH-1:0] y;
  r400_t                 r;

  logic                  in_vld;
  logic [SUM_W-1:0]      in_d;
  month_t                in_m;
  logic [YEAR_WIDTH-1:0] in_y;
  r400_t                 in_r;
  mday_t                 len;
  logic                  roll;

  assign {in_vld, in_d, in_m, in_y, in_r} = pop_data;
  assign pop  = (state == B_IDLE) && !q_stat.empty;
  assign len  = month_len(m, is_leap(r));
  assign roll = (d > SUM_W'(len));

  // One month rollover per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_stat.empty) begin
            vld   <= in_vld;
            d     <= in_d;
            m     <= in_m;
            y     <= in_y;
            r     <= in_r;
            state <= B_RUN;
          end
        end
        B_RUN: begin
          if (!vld) begin
            done          <= 1'b1;
            date_valid    <= 1'b0;
            new_day       <= '0;
            new_month     <= '0;
            new_year      <= '0;
            year_overflow <= 1'b0;
            state         <= B_IDLE;
          end else if (roll) begin
            d <= d - SUM_W'(len);
            if (m == MON_DEC) begin
              if (y == YEAR_MAX) begin
                // past the last year: saturate to its final day
                done          <= 1'b1;
                date_valid    <= 1'b1;
                new_day       <= LEN_LONG;
                new_month     <= MON_DEC;
                new_year      <= YEAR_MAX;
                year_overflow <= 1'b1;
                state         <= B_IDLE;
              end else begin
                m <= MON_JAN;
                y <= y + 1'b1;
                r <= (r == r400_t'(LEAP_CYCLE - 1)) ? '0 : r + 1'b1;
              end
            end else begin
              m <= m + 1'b1;
            end
          end else begin
            done          <= 1'b1;
            date_valid    <= 1'b1;
            new_day       <= d[4:0];
            new_month     <= m;
            new_year      <= y;
            year_overflow <= 1'b0;
            state         <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `GDAD_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than a cycle")
  `GDAD_ASSERT_IMP(a_month_range, clk, rst, (state == B_RUN) && vld, (m >= MON_JAN) && (m <= MON_DEC), "month out of range")

endmodule

FILE: rtl/core/gregorian_date_add_days.sv
`timescale 1ns / 1ps
// Gregorian date adder: adds a day count to a day/month/year date.
// Input: drive start_day, start_month, start_year and add_days with start
// high; the word is taken at a rising edge where start is high and busy low.
// Output: done is high for exactly one cycle with date_valid, new_day,
// new_month, new_year and year_overflow; the receiver cannot stall it.
// An invalid start date gives date_valid low and all other fields zero.
// Passing the end of the last year saturates to 31 December of that year
// with year_overflow set.
// From accept to result: the front end's S_QUOT, S_REM and S_PUSH states,
//   the queue, then the back end's B_IDLE load, one B_RUN step per month
//   rollover (none for an invalid date) and a last B_RUN step that writes
//   the result; a year overflow writes it on its last rollover step instead.
// The front end reduces the year modulo 400 in S_QUOT and S_REM, then hands
// the word to a two-word queue in S_PUSH, stalling there while the queue is
// full; it takes no new word until that push is done. The back end rolls one
// month per cycle and loads each word from the queue in B_IDLE.
// Reset (rst, synchronous) empties the queue and idles both ends.

module gregorian_date_add_days import gdad_pkg::*; #(
  parameter int DAY_COUNT_WIDTH = 16,
  parameter int YEAR_WIDTH      = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [4:0]                 start_day,
  input  logic [3:0]                 start_month,
  input  logic [YEAR_WIDTH-1:0]      start_year,
  input  logic [DAY_COUNT_WIDTH-1:0] add_days,
  output logic                       done,
  output logic                       date_valid,
  output logic [4:0]                 new_day,
  output logic [3:0]                 new_month,
  output logic [YEAR_WIDTH-1:0]      new_year,
  output logic                       year_overflow
);

  localparam int ITEM_W = DAY_COUNT_WIDTH + YEAR_WIDTH + 15;

  q_status_t         q_stat;
  logic              push;
  logic              pop;
  logic [ITEM_W-1:0] push_data;
  logic [ITEM_W-1:0] pop_data;

  gdad_front #(
    .DAY_COUNT_WIDTH (DAY_COUNT_WIDTH),
    .YEAR_WIDTH      (YEAR_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .start_day   (start_day),
    .start_month (start_month),
    .start_year  (start_year),
    .add_days    (add_days),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  gdad_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  gdad_back #(
    .DAY_COUNT_WIDTH (DAY_COUNT_WIDTH),
    .YEAR_WIDTH      (YEAR_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .pop           (pop),
    .pop_data      (pop_data),
    .done          (done),
    .date_valid    (date_valid),
    .new_day       (new_day),
    .new_month     (new_month),
    .new_year      (new_year),
    .year_overflow (year_overflow)
  );

endmodule

FILE: tb/gregorian_date_add_days_checker.sv
`timescale 1ns / 1ps

// Watches both sides of the date adder, works out the date each word should
// give and compares every result against the oldest outstanding one.
module gregorian_date_add_days_checker import gdad_pkg::*; #(
  parameter int DAY_COUNT_WIDTH = 16,
  parameter int YEAR_WIDTH      = 14
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [4:0]                 start_day,
  input  logic [3:0]                 start_month,
  input  logic [YEAR_WIDTH-1:0]      start_year,
  input  logic [DAY_COUNT_WIDTH-1:0] add_days,
  input  logic                       done,
  input  logic                       date_valid,
  input  logic [4:0]                 new_day,
  input  logic [3:0]                 new_month,
  input  logic [YEAR_WIDTH-1:0]      new_year,
  input  logic                       year_overflow,
  output int                         mismatches,
  output int                         words_pending
);

  localparam int unsigned LAST_YEAR = (1 << YEAR_WIDTH) - 1;

  typedef struct packed {
    logic                  valid;
    mday_t                 day;
    month_t                month;
    logic [YEAR_WIDTH-1:0] year;
    logic                  ovf;
  } date_result_t;

  date_result_t expected_dates[$];
  int           fault_count = 0;
  int           results_seen = 0;

  initial begin
    mismatches    = 0;
    words_pending = 0;
  end

  // Gregorian rule: every 4th year, except centuries not divisible by 400
  function automatic bit leap_year(int unsigned y);
    return (y % LEAP_CYCLE == 0) || ((y % 4 == 0) && (y % CENTURY != 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    int unsigned len;
    case (m) inside
      MON_FEB:                            len = leap_year(y) ? 32'(LEN_FEB_LEAP) : 32'(LEN_FEB);
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 32'(LEN_SHORT);
      default:                            len = 32'(LEN_LONG);
    endcase
    return len;
  endfunction

  // Expected result for one word: screen the date, then roll month by month
  function automatic date_result_t add_to_date(mday_t d_in, month_t m_in,
                                               logic [YEAR_WIDTH-1:0] y_in,
                                               logic [DAY_COUNT_WIDTH-1:0] n);
    date_result_t r;
    int unsigned  d;
    int unsigned  m;
    int unsigned  y;
    bit           rolling;
    r = '0;
    d = 32'(d_in);
    m = 32'(m_in);
    y = 32'(y_in);
    if (y == 0 || m < 32'(MON_JAN) || m > 32'(MON_DEC) || d == 0 ||
        d > days_in_month(m, y))
      return r;
    d       = d + 32'(n);
    rolling = 1'b1;
    while (rolling && d > days_in_month(m, y)) begin
      d = d - days_in_month(m, y);
      m = m + 1;
      if (m > 32'(MON_DEC)) begin
        m = 32'(MON_JAN);
        if (y >= LAST_YEAR) begin
          // past the last representable year: pin to its final day
          r.ovf   = 1'b1;
          d       = 32'(LEN_LONG);
          m       = 32'(MON_DEC);
          rolling = 1'b0;
        end else begin
          y = y + 1;
        end
      end
    end
    r.valid = 1'b1;
    r.day   = mday_t'(d);
    r.month = month_t'(m);
    r.year  = YEAR_WIDTH'(y);
    return r;
  endfunction

  // Results are taken before new words so an edge carrying both stays ordered
  always @(posedge clk) begin
    date_result_t got;
    date_result_t want;
    if (!rst) begin
      if (done) begin
        got.valid = date_valid;
        got.day   = new_day;
        got.month = new_month;
        got.year  = new_year;
        got.ovf   = year_overflow;
        if (expected_dates.size() == 0) begin
          fault_count = fault_count + 1;
          if (fault_count <= 10)
            $display("ERROR result %0d: no word outstanding, ", results_seen,
                     "got valid=%0d %0d/%0d/%0d ovf=%0d",
                     got.valid, got.day, got.month, got.year, got.ovf);
        end else begin
          want = expected_dates.pop_front();
          if (got !== want) begin
            fault_count = fault_count + 1;
            if (fault_count <= 10)
              $display("ERROR result %0d: expected valid=%0d %0d/%0d/%0d ovf=%0d, ",
                       results_seen, want.valid, want.day, want.month, want.year,
                       want.ovf, "got valid=%0d %0d/%0d/%0d ovf=%0d",
                       got.valid, got.day, got.month, got.year, got.ovf);
          end
        end
        results_seen = results_seen + 1;
      end
      if (start && !busy)
        expected_dates.push_back(add_to_date(start_day, start_month, start_year, add_days));
    end
    mismatches    <= fault_count;
    words_pending <= expected_dates.size();
  end

endmodule

FILE: tb/tb_gregorian_date_add_days.sv
`timescale 1ns / 1ps

module tb_gregorian_date_add_days;

  localparam int DCW = 16;
  localparam int YW  = 14;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  logic [4:0]     start_day = '0;
  logic [3:0]     start_month = '0;
  logic [YW-1:0]  start_year = '0;
  logic [DCW-1:0] add_days = '0;
  logic           done;
  logic           date_valid;
  logic [4:0]     new_day;
  logic [3:0]     new_month;
  logic [YW-1:0]  new_year;
  logic           year_overflow;
  int             mismatches;
  int             words_pending;

  always #1 clk = ~clk;

  gregorian_date_add_days #(
    .DAY_COUNT_WIDTH(DCW),
    .YEAR_WIDTH     (YW)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .start_day    (start_day),
    .start_month  (start_month),
    .start_year   (start_year),
    .add_days     (add_days),
    .done         (done),
    .date_valid   (date_valid),
    .new_day      (new_day),
    .new_month    (new_month),
    .new_year     (new_year),
    .year_overflow(year_overflow)
  );

  gregorian_date_add_days_checker #(
    .DAY_COUNT_WIDTH(DCW),
    .YEAR_WIDTH     (YW)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .start_day    (start_day),
    .start_month  (start_month),
    .start_year   (start_year),
    .add_days     (add_days),
    .done         (done),
    .date_valid   (date_valid),
    .new_day      (new_day),
    .new_month    (new_month),
    .new_year     (new_year),
    .year_overflow(year_overflow),
    .mismatches   (mismatches),
    .words_pending(words_pending)
  );

  // Present a word and hold it until the block takes it
  task automatic offer_word(input logic [4:0] d, input logic [3:0] m,
                            input logic [YW-1:0] y, input logic [DCW-1:0] n);
    start       <= 1'b1;
    start_day   <= d;
    start_month <= m;
    start_year  <= y;
    add_days    <= n;
    do @(posedge clk); while (busy);
  endtask

  // Random gap after a word; fields carry junk that must be ignored
  task automatic maybe_idle(input bit allowed);
    int gap;
    if (allowed && $urandom_range(99) < 30) begin
      gap          = $urandom_range(1, 6);
      start       <= 1'b0;
      start_day   <= 5'($urandom);
      start_month <= 4'($urandom);
      start_year  <= YW'($urandom);
      add_days    <= DCW'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding word has its result
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [4:0]     d;
    logic [3:0]     m;
    logic [YW-1:0]  y;
    logic [DCW-1:0] n;
    int unsigned    kind;
    int unsigned    pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, leap rules, rollovers, invalid dates, overflow
    offer_word(5'd1,  4'd1,  14'd1,     16'd0);     maybe_idle(1'b1);
    offer_word(5'd31, 4'd12, 14'd16383, 16'd0);     maybe_idle(1'b1);
    offer_word(5'd31, 4'd12, 14'd16383, 16'd1);     maybe_idle(1'b1);
    offer_word(5'd1,  4'd1,  14'd16383, 16'd65535); maybe_idle(1'b1);
    offer_word(5'd31, 4'd1,  14'd1,     16'd65535); maybe_idle(1'b1);
    offer_word(5'd1,  4'd1,  14'd1,     16'd65535); maybe_idle(1'b1);
    offer_word(5'd29, 4'd2,  14'd2000,  16'd0);     maybe_idle(1'b1);
    offer_word(5'd29, 4'd2,  14'd1900,  16'd0);     maybe_idle(1'b1);
    offer_word(5'd29, 4'd2,  14'd2024,  16'd365);   maybe_idle(1'b1);
    offer_word(5'd29, 4'd2,  14'd2023,  16'd5);     maybe_idle(1'b1);
    offer_word(5'd28, 4'd2,  14'd2100,  16'd1);     maybe_idle(1'b1);
    offer_word(5'd28, 4'd2,  14'd2024,  16'd1);     maybe_idle(1'b1);
    offer_word(5'd0,  4'd5,  14'd2000,  16'd10);    maybe_idle(1'b1);
    offer_word(5'd1,  4'd0,  14'd2000,  16'd10);    maybe_idle(1'b1);
    offer_word(5'd1,  4'd13, 14'd2000,  16'd10);    maybe_idle(1'b1);
    offer_word(5'd31, 4'd15, 14'd16383, 16'd65535); maybe_idle(1'b1);
    offer_word(5'd1,  4'd1,  14'd0,     16'd10);    maybe_idle(1'b1);
    offer_word(5'd31, 4'd4,  14'd2021,  16'd1);     maybe_idle(1'b1);
    offer_word(5'd31, 4'd12, 14'd1999,  16'd1);     maybe_idle(1'b1);
    offer_word(5'd30, 4'd6,  14'd2021,  16'd1);     maybe_idle(1'b1);
    offer_word(5'd31, 4'd7,  14'd2021,  16'd31);    maybe_idle(1'b1);
    offer_word(5'd15, 4'd8,  14'd16200, 16'd65535); maybe_idle(1'b1);
    offer_word(5'd31, 4'd12, 14'd16382, 16'd365);
    drain();

    // Random: mostly well-formed dates, some near the top year, some junk
    for (int i = 0; i < 250; i++) begin
      kind = $urandom_range(99);
      pick = $urandom_range(99);
      y    = YW'($urandom_range(1, 16383));
      m    = 4'($urandom_range(1, 12));
      d    = ($urandom_range(9) == 0) ? 5'($urandom_range(29, 31)) :
                                        5'($urandom_range(1, 28));
      n    = (pick < 60) ? DCW'($urandom_range(0, 400)) :
             (pick < 85) ? DCW'($urandom_range(0, 4000)) : DCW'($urandom);
      if (kind < 8) begin
        // close enough to the last year for a large count to overflow
        y = YW'($urandom_range(16200, 16383));
        n = DCW'($urandom_range(30000, 65535));
      end else if (kind < 12) begin
        y = YW'($urandom_range(1, 3));
      end else if (kind < 24) begin
        // raw fields, mostly failing the calendar check
        d = 5'($urandom);
        m = 4'($urandom);
        y = ($urandom_range(3) == 0) ? '0 : YW'($urandom);
        n = DCW'($urandom);
      end
      offer_word(d, m, y, n);
      if (i == 120)
        drain();
      else
        maybe_idle(!(i >= 150 && i < 210));
    end

    drain();
    repeat (2400) @(posedge clk);
    if (mismatches == 0 && words_pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Hang guard, several times the slowest legal run
  initial begin
    #6000000;
    $display("FAIL");
    $finish;
  end

endmodule
